>>> rtl/core/tsf_pkg.sv
`timescale 1ns / 1ps

package tsf_pkg;

  // continuity counter slots
  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CC_W     = 4;

  // packet geometry
  localparam logic [7:0] PKT_BODY  = 8'd184;
  localparam logic [7:0] ADAPT_MAX = 8'd183;
  localparam logic [7:0] CLK_REF_BYTES = 8'd6;
  localparam logic [7:0] AF_HEAD_BYTES = 8'd2;
  localparam logic [7:0] SYNC_BYTE = 8'h47;

  // adaptation field control codes
  localparam logic [1:0] AFC_PAYLOAD = 2'd1;
  localparam logic [1:0] AFC_ADAPT   = 2'd2;
  localparam logic [1:0] AFC_BOTH    = 2'd3;

  // adaptation flag bits
  localparam logic [7:0] FLAG_DISCO = 8'h80;
  localparam logic [7:0] FLAG_PCR   = 8'h10;
  localparam logic [7:0] FLAG_OPCR  = 8'h08;

  typedef struct packed {
    logic [3:0]  channel;
    logic [12:0] pid;
    logic [1:0]  scramble_mode;
    logic [15:0] bytes_left;
    logic        is_psi;
    logic        want_discontinuity;
    logic        want_pcr;
    logic        want_opcr;
  } in_item_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic [7:0]  adapt_length;
    logic [7:0]  adapt_flags;
    logic [7:0]  payload_bytes;
    logic [7:0]  stuffing_bytes;
    logic        unit_done;
  } out_item_t;

  // packet layout decided from one item
  typedef struct packed {
    logic [1:0] afc;
    logic [7:0] alen;
    logic [7:0] flags;
    logic [7:0] payload;
    logic [7:0] stuff;
    logic       done;
  } plan_t;

endpackage

>>> rtl/core/tsf_ram.sv
`timescale 1ns / 1ps

module tsf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tsf_plan.sv
`timescale 1ns / 1ps

module tsf_plan (
  input  tsf_pkg::in_item_t item_i,
  output tsf_pkg::plan_t    plan_o
);

  import tsf_pkg::*;

  logic [7:0] flags;
  logic [7:0] space_base;
  logic [7:0] space_fin;
  logic [7:0] payload;
  logic [1:0] afc;
  logic       short_unit;

  // adaptation flags, masked for psi
  always_comb begin
    flags = 8'd0;
    if (!item_i.is_psi && item_i.want_discontinuity) flags = flags | FLAG_DISCO;
    if (!item_i.is_psi && item_i.want_pcr)           flags = flags | FLAG_PCR;
    if (!item_i.is_psi && item_i.want_opcr)          flags = flags | FLAG_OPCR;
  end

  // space left for payload after clock references and the field head
  always_comb begin
    space_base = PKT_BODY;
    if (!item_i.is_psi && item_i.want_pcr)  space_base = space_base - CLK_REF_BYTES;
    if (!item_i.is_psi && item_i.want_opcr) space_base = space_base - CLK_REF_BYTES;
    if (flags != 8'd0)                      space_base = space_base - AF_HEAD_BYTES;
  end

  assign short_unit = item_i.bytes_left < {8'd0, space_base};

  // payload split and adaptation choice
  always_comb begin
    space_fin = space_base;
    if (short_unit) begin
      payload = item_i.bytes_left[7:0];
      if (flags == 8'd0) begin
        space_fin = space_base - 8'd1;
        if (space_fin > payload) space_fin = space_fin - 8'd1;
      end
      afc = AFC_BOTH;
    end else begin
      payload = space_base;
      afc = (flags == 8'd0) ? AFC_PAYLOAD : AFC_BOTH;
    end
    if (payload == 8'd0) afc = AFC_ADAPT;
  end

  // result fields
  always_comb begin
    plan_o.afc     = afc;
    plan_o.flags   = flags;
    plan_o.payload = payload;
    plan_o.done    = (payload != 8'd0) && ({8'd0, payload} >= item_i.bytes_left);
    if (afc[1]) begin
      plan_o.alen  = ADAPT_MAX - payload;
      plan_o.stuff = space_fin - payload;
    end else begin
      plan_o.alen  = 8'd0;
      plan_o.stuff = 8'd0;
    end
  end

endmodule

>>> rtl/core/ts_packet_framer.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o  | in_item_i  (tsf_pkg::in_item_t)
// out     | output    | out_valid_o/out_stall_i| out_item_o (tsf_pkg::out_item_t)
//
// one item per cycle while out_stall_i is low; accept -> stage one -> output register
// stage one reads the channel counter from a registered-read RAM, stage two adds it,
// writes it back and fills the output register; a forward register covers the
// back-to-back case on one channel
// reset clears output valid and the counter valid bits, and sets the unit-start flag
// a stalled output holds its item; the input stalls only when both stages are full

module ts_packet_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsf_pkg::out_item_t out_item_o
);

  import tsf_pkg::*;

  plan_t            plan;
  logic             in_accept;
  logic             s1_move;
  logic [CH_AW-1:0] in_addr;
  logic             in_chok;

  logic             s1_valid_q;
  plan_t            s1_plan_q;
  logic [12:0]      s1_pid_q;
  logic [1:0]       s1_scr_q;
  logic [CH_AW-1:0] s1_addr_q;
  logic             s1_chok_q;

  logic [CC_W-1:0]  ram_rdata;
  logic [CC_W-1:0]  cc;
  logic             wr_en;
  logic [CC_W-1:0]  wr_data;

  logic             fwd_valid_q;
  logic [CH_AW-1:0] fwd_addr_q;
  logic [CC_W-1:0]  fwd_data_q;
  logic [CHANNELS-1:0] cnt_vld_q;

  logic             usp_q;
  logic             usp_d;
  logic             out_valid_q;
  out_item_t        out_item_q;
  out_item_t        out_item_d;

  // layout decision on the incoming item
  tsf_plan u_plan (
    .item_i (in_item_i),
    .plan_o (plan)
  );

  // handshake
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_chok    = 32'(in_item_i.channel) < CHANNELS;
  assign in_addr    = CH_AW'(in_item_i.channel);

  // counter store
  tsf_ram #(
    .WIDTH (CC_W),
    .DEPTH (CHANNELS)
  ) u_cc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // stage one registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_plan_q <= plan;
      s1_pid_q  <= in_item_i.pid;
      s1_scr_q  <= in_item_i.scramble_mode;
      s1_addr_q <= in_addr;
      s1_chok_q <= in_chok;
    end
  end

  // counter value: forwarded write, stored value, or reset value
  always_comb begin
    if (!s1_chok_q) begin
      cc = '0;
    end else if (fwd_valid_q && (fwd_addr_q == s1_addr_q)) begin
      cc = fwd_data_q;
    end else if (cnt_vld_q[s1_addr_q]) begin
      cc = ram_rdata;
    end else begin
      cc = '0;
    end
  end

  assign wr_en   = s1_valid_q && s1_move && s1_plan_q.afc[0] && s1_chok_q;
  assign wr_data = cc + CC_W'(1);

  // forward register and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
    end else if (wr_en) begin
      fwd_valid_q          <= 1'b1;
      cnt_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wr_data;
    end
  end

  // result assembly
  always_comb begin
    out_item_d.header_word    = {SYNC_BYTE, 1'b0, usp_q, 1'b0, s1_pid_q[12:8],
                                 s1_pid_q[7:0], s1_scr_q, s1_plan_q.afc, cc};
    out_item_d.adapt_length   = s1_plan_q.alen;
    out_item_d.adapt_flags    = s1_plan_q.flags;
    out_item_d.payload_bytes  = s1_plan_q.payload;
    out_item_d.stuffing_bytes = s1_plan_q.stuff;
    out_item_d.unit_done      = s1_plan_q.done;
  end

  // unit start follows the last packet that carried payload
  always_comb begin
    usp_d = usp_q;
    if (s1_valid_q && s1_move && (s1_plan_q.payload != 8'd0)) usp_d = s1_plan_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usp_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      usp_q <= usp_d;
      if (s1_move) out_valid_q <= s1_valid_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  a_adapt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.header_word[5])
      |-> ((out_item_o.adapt_length + out_item_o.payload_bytes) == ADAPT_MAX))
    else $error("adaptation length does not match payload");

  a_done_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.unit_done) |-> (out_item_o.payload_bytes != 8'd0))
    else $error("unit done without payload");

  a_fwd_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fwd_valid_q && cnt_vld_q[fwd_addr_q]
               && (out_item_o.header_word[3:0] + CC_W'(1) == fwd_data_q)))
    else $error("counter write back does not follow delivered header");

endmodule
